// ===== rtl/core/aafb_pkg.sv =====
// Shared constants, types and frame byte lookup for the ADC to ASCII frame builder.
// No dependencies; every other file of the block refers to it by scoped names.
package aafb_pkg;

    localparam int SAMPLE_W = 12;
    localparam int S_TDATA_W = 16;
    localparam int BYTE_W = 8;
    localparam int FRAME_LEN = 8;
    localparam int IDX_W = $clog2(FRAME_LEN);
    localparam int SCALED_W = 21;
    localparam int POS_W = 11;
    localparam int REM_W = 10;
    localparam int REM2_W = 7;
    localparam int DIGIT_W = 4;

    localparam logic [SCALED_W:0] RECIP_1250 = 22'd3435974;
    localparam int RECIP_SHIFT = 32;
    localparam logic [POS_W-1:0] POS_OFFSET = 11'd263;
    localparam logic [POS_W-1:0] THOUSAND = 11'd1000;
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int RECIP_100_SHIFT = 19;
    localparam logic [6:0] RECIP_10 = 7'd103;
    localparam int RECIP_10_SHIFT = 10;

    localparam logic [BYTE_W-1:0] BYTE_STX = 8'h02;
    localparam logic [BYTE_W-1:0] BYTE_DOT = 8'h2E;
    localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] BYTE_ETX = 8'h03;
    localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

    localparam logic [IDX_W-1:0] IDX_STX = 3'd0;
    localparam logic [IDX_W-1:0] IDX_THOUSANDS = 3'd1;
    localparam logic [IDX_W-1:0] IDX_DOT = 3'd2;
    localparam logic [IDX_W-1:0] IDX_HUNDREDS = 3'd3;
    localparam logic [IDX_W-1:0] IDX_TENS = 3'd4;
    localparam logic [IDX_W-1:0] IDX_ONES = 3'd5;
    localparam logic [IDX_W-1:0] IDX_CR = 3'd6;
    localparam logic [IDX_W-1:0] IDX_ETX = 3'd7;

    typedef struct packed {
        logic               thousands;
        logic [DIGIT_W-1:0] hundreds;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] ones;
    } digits_t;

    function automatic logic [BYTE_W-1:0] frame_byte_at(
        input logic [IDX_W-1:0] idx,
        input digits_t          dig
    );
        logic [BYTE_W-1:0] b;
        unique case (idx)
            IDX_STX:       b = BYTE_STX;
            IDX_THOUSANDS: b = {ASCII_DIGIT_HI, 3'b000, dig.thousands};
            IDX_DOT:       b = BYTE_DOT;
            IDX_HUNDREDS:  b = {ASCII_DIGIT_HI, dig.hundreds};
            IDX_TENS:      b = {ASCII_DIGIT_HI, dig.tens};
            IDX_ONES:      b = {ASCII_DIGIT_HI, dig.ones};
            IDX_CR:        b = BYTE_CR;
            IDX_ETX:       b = BYTE_ETX;
            default:       b = BYTE_ETX;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/core/adc_to_ascii_frame_builder.sv =====
// Top level of the ADC to ASCII frame builder.
// Depends on aafb_pkg, aafb_conv and aafb_ser.
//
// The slave stream takes one 12-bit ADC sample per item in s_tdata[11:0].
// The sample is scaled to a position, (511 * sample) / 1250 + 263, split into
// decimal digits, and sent on the master stream as an eight-item ASCII frame:
// STX, thousands digit, '.', hundreds, tens, ones, CR, ETX. m_tlast marks ETX.
// An accepted sample passes a seven-stage conversion pipeline, a digit
// register and the output byte register before the first byte of its frame.
// The master side moves one byte per cycle while m_tready is high; the
// serializer's byte counter steps through the eight items of a frame and
// takes the next digits as ETX is sent. A new sample may be accepted in any
// cycle in which the pipeline can shift, so several samples can be in flight
// at once. On a receiver stall the output byte holds and the pipeline shifts
// until a sample reaches its last stage, then stalls s_tready. Reset empties
// the pipeline and serializer and clears m_tvalid; no sample in flight survives it.
module adc_to_ascii_frame_builder (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [aafb_pkg::S_TDATA_W-1:0]   s_tdata,   // [11:0] sample, [15:12] zero
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [aafb_pkg::BYTE_W-1:0]      m_tdata,   // [7:0] frame_byte
    output logic                             m_tlast
);

    logic              conv_valid;
    logic              ser_take;
    aafb_pkg::digits_t conv_digits;

    aafb_conv u_conv (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_sample  (s_tdata[aafb_pkg::SAMPLE_W-1:0]),
        .out_valid  (conv_valid),
        .out_take   (ser_take),
        .out_digits (conv_digits)
    );

    aafb_ser u_ser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (conv_valid),
        .in_take   (ser_take),
        .in_digits (conv_digits),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== rtl/core/aafb_conv.sv =====
// Pipeline that scales a sample to a position and splits it into decimal digits.
// Depends on aafb_pkg.
module aafb_conv (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [aafb_pkg::SAMPLE_W-1:0] in_sample,
    output logic                         out_valid,
    input  logic                         out_take,
    output aafb_pkg::digits_t            out_digits
);

    logic                           en;
    logic [6:0]                     valid_reg;
    logic [aafb_pkg::SAMPLE_W-1:0]  sample_reg;
    logic [aafb_pkg::SCALED_W-1:0]  scaled_reg;
    logic [aafb_pkg::POS_W-1:0]     pos_reg;
    logic                           th4_reg;
    logic [aafb_pkg::REM_W-1:0]     rem4_reg;
    logic                           th5_reg;
    logic [aafb_pkg::DIGIT_W-1:0]   h5_reg;
    logic [aafb_pkg::REM_W-1:0]     rem5_reg;
    logic                           th6_reg;
    logic [aafb_pkg::DIGIT_W-1:0]   h6_reg;
    logic [aafb_pkg::REM2_W-1:0]    rem6_reg;
    aafb_pkg::digits_t              dig_reg;

    logic [aafb_pkg::SCALED_W-1:0]  scaled_next;
    logic [42:0]                    pos_prod;
    logic [aafb_pkg::POS_W-1:0]     pos_next;
    logic                           th4_next;
    logic [aafb_pkg::POS_W-1:0]     pos_less;
    logic [aafb_pkg::REM_W-1:0]     rem4_next;
    logic [22:0]                    h_prod;
    logic [aafb_pkg::REM_W-1:0]     hund;
    logic [aafb_pkg::REM_W-1:0]     rem_diff;
    logic [13:0]                    t_prod;
    logic [aafb_pkg::DIGIT_W-1:0]   t_next;
    logic [aafb_pkg::REM2_W-1:0]    tens_val;
    logic [aafb_pkg::REM2_W-1:0]    ones_diff;
    aafb_pkg::digits_t              dig_next;

    assign en        = !valid_reg[6] || out_take;
    assign in_ready  = en;
    assign out_valid = valid_reg[6];
    assign out_digits = dig_reg;

    assign scaled_next = {sample_reg, 9'b0} - {9'b0, sample_reg};
    assign pos_prod    = 43'(scaled_reg) * 43'(aafb_pkg::RECIP_1250);
    assign pos_next    = pos_prod[42:aafb_pkg::RECIP_SHIFT] + aafb_pkg::POS_OFFSET;
    assign th4_next    = pos_reg >= aafb_pkg::THOUSAND;
    assign pos_less    = pos_reg - aafb_pkg::THOUSAND;
    assign rem4_next   = th4_next ? pos_less[aafb_pkg::REM_W-1:0]
                                  : pos_reg[aafb_pkg::REM_W-1:0];
    assign h_prod      = 23'(rem4_reg) * 23'(aafb_pkg::RECIP_100);
    assign hund        = 10'(h5_reg) * 10'd100;
    assign rem_diff    = rem5_reg - hund;
    assign t_prod      = 14'(rem6_reg) * 14'(aafb_pkg::RECIP_10);
    assign t_next      = t_prod[13:aafb_pkg::RECIP_10_SHIFT];
    assign tens_val    = 7'(t_next) * 7'd10;
    assign ones_diff   = rem6_reg - tens_val;

    always_comb begin
        dig_next.thousands = th6_reg;
        dig_next.hundreds  = h6_reg;
        dig_next.tens      = t_next;
        dig_next.ones      = ones_diff[aafb_pkg::DIGIT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sample_reg <= in_sample;
            scaled_reg <= scaled_next;
            pos_reg    <= pos_next;
            th4_reg    <= th4_next;
            rem4_reg   <= rem4_next;
            th5_reg    <= th4_reg;
            h5_reg     <= h_prod[22:aafb_pkg::RECIP_100_SHIFT];
            rem5_reg   <= rem4_reg;
            th6_reg    <= th5_reg;
            h6_reg     <= h5_reg;
            rem6_reg   <= rem_diff[aafb_pkg::REM2_W-1:0];
            dig_reg    <= dig_next;
        end
    end

endmodule

// ===== rtl/core/aafb_ser.sv =====
// Frame serializer: turns one set of digits into eight ASCII bytes on a registered stream.
// Depends on aafb_pkg.
module aafb_ser (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_take,
    input  aafb_pkg::digits_t          in_digits,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [aafb_pkg::BYTE_W-1:0] m_tdata,
    output logic                       m_tlast
);

    logic                           out_adv;
    logic                           at_end;
    logic                           dig_valid_reg;
    logic [aafb_pkg::IDX_W-1:0]     idx_reg;
    aafb_pkg::digits_t              dig_reg;
    logic                           tvalid_reg;
    logic [aafb_pkg::BYTE_W-1:0]    tdata_reg;
    logic                           tlast_reg;

    assign out_adv = !tvalid_reg || m_tready;
    assign at_end  = idx_reg == aafb_pkg::IDX_ETX;
    assign in_take = !dig_valid_reg || (out_adv && at_end);

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dig_valid_reg <= 1'b0;
            idx_reg       <= aafb_pkg::IDX_STX;
            tvalid_reg    <= 1'b0;
        end else begin
            if (out_adv) begin
                tvalid_reg <= dig_valid_reg;
                if (dig_valid_reg) begin
                    idx_reg <= idx_reg + aafb_pkg::IDX_W'(1);
                end
            end
            if (in_take) begin
                dig_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && dig_valid_reg) begin
            tdata_reg <= aafb_pkg::frame_byte_at(idx_reg, dig_reg);
            tlast_reg <= at_end;
        end
        if (in_take) begin
            dig_reg <= in_digits;
        end
    end

endmodule

// ===== rtl/core/aafb_checker.sv =====
// Port-level checks on the frame stream of the ADC to ASCII frame builder.
// Depends on aafb_pkg; bound to adc_to_ascii_frame_builder at the end of this file.
module aafb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("Stalled output item changed.");

    a_last_etx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == aafb_pkg::BYTE_ETX)
        else $error("Last item of a frame is not ETX.");

    a_next_stx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid || m_tdata == aafb_pkg::BYTE_STX)
        else $error("Frame does not start with STX.");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Output valid after reset.");

endmodule

bind adc_to_ascii_frame_builder aafb_checker u_aafb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
